@@ hw/rtl/lcdc_pkg.sv @@
package lcdc_pkg;

   // Default palette depth in 16-bit entries.
   localparam int PALETTE_ENTRIES_DEFAULT = 256;

   // Width of the palette row (word) field taken from a bus address.
   localparam int PAL_ROW_ADDR_W = 9;

   // Command codes of one transaction on the request channel.
   typedef enum logic [1:0] {
      CMD_READ       = 2'd0,
      CMD_WRITE      = 2'd1,
      CMD_INVALIDATE = 2'd2,
      CMD_FRAME_DONE = 2'd3
   } cmd_type;

   // Register map, byte offsets within the window.
   localparam logic [11:0] ADDR_CONTROL      = 12'h000;
   localparam logic [11:0] ADDR_TIMING0      = 12'h004;
   localparam logic [11:0] ADDR_TIMING1      = 12'h008;
   localparam logic [11:0] ADDR_TIMING2      = 12'h00C;
   localparam logic [11:0] ADDR_SCAN_BASE    = 12'h010;
   localparam logic [11:0] ADDR_CURRENT_BASE = 12'h018;
   localparam logic [11:0] ADDR_IRQ_STATUS   = 12'h020;
   localparam logic [11:0] ADDR_IRQ_MASK     = 12'h024;
   localparam logic [11:0] ADDR_DITHER_FIRST = 12'h028;
   localparam logic [11:0] ADDR_DITHER_LAST  = 12'h044;

   // Reset values.
   localparam logic [1:0] BURST_RESET = 2'd2;
   localparam logic [3:0] MASK_RESET  = 4'hF;
   localparam logic [7:0][31:0] DITHER_RESET = {
      32'hFFFFDFFF, 32'hDFDFDFDD, 32'hDDDDD5DD, 32'hD5D5D555,
      32'h555592C9, 32'h92491249, 32'h11110421, 32'h01010000
   };

   // Request and result transactions.
   typedef struct packed {
      cmd_type     command;
      logic [11:0] address;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_level;
      logic [10:0] line_width_pixels;
      logic [12:0] line_bytes;
   } rsp_type;

   // Palette RAM access control.
   typedef struct packed {
      logic                      wr_en;
      logic                      rd_en;
      logic [PAL_ROW_ADDR_W-1:0] row;
   } pal_ctrl_type;

   // Exchange the two 16-bit halves of a word.
   function automatic logic [31:0] swap_halves(input logic [31:0] value);
      return {value[15:0], value[31:16]};
   endfunction

endpackage

@@ hw/rtl/lcdc_palette_ram.sv @@
module lcdc_palette_ram import lcdc_pkg::*; #(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  pal_ctrl_type ctrl,
   input  logic [31:0]  wr_data,
   output logic [31:0]  rd_data
);

   // One row holds two entries: the odd entry in the upper half.
   localparam int ROWS  = PALETTE_ENTRIES / 2;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [31:0]     mem [ROWS];
   logic [31:0]     mem_q_ff;
   logic [ROWS-1:0] row_valid_ff;
   logic            hit_ff;
   logic [ROW_W-1:0] row_idx;

   assign row_idx = ctrl.row[ROW_W-1:0];

   // Storage array with a registered read port.
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[row_idx] <= wr_data;
      end
      if (ctrl.rd_en) begin
         mem_q_ff <= mem[row_idx];
         hit_ff   <= row_valid_ff[row_idx];
      end
   end

   // A row that was never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (ctrl.wr_en) begin
         row_valid_ff[row_idx] <= 1'b1;
      end
   end

   assign rd_data = hit_ff ? mem_q_ff : 32'd0;

endmodule

@@ hw/rtl/lcd_controller_register_block_unit.sv @@
// Register block of an LCD controller.
// Request channel: a transaction (command, address, write data in req_item) is
// taken at a rising edge where start is high and busy is low. busy is held low,
// so a new transaction may be issued in every cycle.
// Commands are bus read, bus write, display-invalidate event and frame-done
// event. Every transaction returns exactly one result on rsp_item, marked by
// rsp_strobe for one cycle: the read word (zero for any other command), the
// interrupt level and the line geometry after the transaction.
// Throughput is one transaction per cycle; a result passes through the input
// register, the registered read port of the palette RAM and the result
// register.
// The receiver cannot stall the result channel; results are never held back.
// Synchronous reset clears the pipeline and restores every architectural
// register to its reset value at once. The palette keeps one valid bit per
// two-entry row, so it reads as zero right after reset with no clearing pass.
module lcd_controller_register_block_unit import lcdc_pkg::*; #(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   localparam int PAL_ROWS = PALETTE_ENTRIES / 2;

   // Input register.
   logic    accept;
   logic    s1_valid_ff;
   req_type s1_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= req_item;
      end
   end

   // Architectural registers.
   logic        out_pixel_mode_ff, out_pixel_mode_in;
   logic        dma_watermark_ff, dma_watermark_in;
   logic [1:0]  burst_length_ff, burst_length_in;
   logic        endian_mode_ff, endian_mode_in;
   logic [1:0]  pixel_size_code_ff, pixel_size_code_in;
   logic        tft_mode_ff, tft_mode_in;
   logic        color_mode_ff, color_mode_in;
   logic        display_enable_ff, display_enable_in;
   logic [21:0] horizontal_timing_ff, horizontal_timing_in;
   logic [5:0]  width_code_ff, width_code_in;
   logic [21:0] vertical_timing_ff, vertical_timing_in;
   logic [9:0]  height_lines_ff, height_lines_in;
   logic [31:0] extra_timing_ff, extra_timing_in;
   logic [31:0] scan_base_ff, scan_base_in;
   logic        base_update_flag_ff, base_update_flag_in;
   logic        invalidate_flag_ff, invalidate_flag_in;
   logic [3:0]  interrupt_mask_ff, interrupt_mask_in;
   logic [7:0][31:0] dither_words_ff, dither_words_in;
   logic        irq_line_ff, irq_line_in;

   // Address decode of the transaction in the input register.
   logic [11:0]               s1_addr;
   logic [31:0]               s1_wdata;
   logic [11:0]               dither_offset;
   logic [2:0]                dither_idx;
   logic                      is_dither;
   logic [PAL_ROW_ADDR_W-1:0] pal_row;
   logic                      pal_hit;
   logic                      is_read;
   logic                      is_write;

   assign s1_addr       = s1_ff.address;
   assign s1_wdata      = s1_ff.write_data;
   assign dither_offset = s1_addr - ADDR_DITHER_FIRST;
   assign dither_idx    = dither_offset[4:2];
   assign is_dither     = (s1_addr >= ADDR_DITHER_FIRST) && (s1_addr <= ADDR_DITHER_LAST)
                          && (s1_addr[1:0] == 2'b00);
   assign pal_row       = s1_addr[10:2];
   assign pal_hit       = s1_addr[11] && (s1_addr[1:0] == 2'b00)
                          && (pal_row < PAL_ROW_ADDR_W'(PAL_ROWS));
   assign is_read       = s1_valid_ff && (s1_ff.command == CMD_READ);
   assign is_write      = s1_valid_ff && (s1_ff.command == CMD_WRITE);

   // Palette RAM; row data is stored with the odd entry in the upper half.
   pal_ctrl_type pal_ctrl;
   logic [31:0]  pal_wr_data;
   logic [31:0]  pal_rd_data;

   assign pal_ctrl.wr_en = is_write && pal_hit;
   assign pal_ctrl.rd_en = is_read && pal_hit;
   assign pal_ctrl.row   = pal_row;
   assign pal_wr_data    = endian_mode_ff ? swap_halves(s1_wdata) : s1_wdata;

   lcdc_palette_ram #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (pal_ctrl),
      .wr_data (pal_wr_data),
      .rd_data (pal_rd_data)
   );

   // Next register state for the transaction in the input register.
   always_comb begin
      out_pixel_mode_in    = out_pixel_mode_ff;
      dma_watermark_in     = dma_watermark_ff;
      burst_length_in      = burst_length_ff;
      endian_mode_in       = endian_mode_ff;
      pixel_size_code_in   = pixel_size_code_ff;
      tft_mode_in          = tft_mode_ff;
      color_mode_in        = color_mode_ff;
      display_enable_in    = display_enable_ff;
      horizontal_timing_in = horizontal_timing_ff;
      width_code_in        = width_code_ff;
      vertical_timing_in   = vertical_timing_ff;
      height_lines_in      = height_lines_ff;
      extra_timing_in      = extra_timing_ff;
      scan_base_in         = scan_base_ff;
      base_update_flag_in  = base_update_flag_ff;
      invalidate_flag_in   = invalidate_flag_ff;
      interrupt_mask_in    = interrupt_mask_ff;
      dither_words_in      = dither_words_ff;
      irq_line_in          = irq_line_ff;

      if (s1_valid_ff) begin
         case (s1_ff.command)
            CMD_WRITE: begin
               // Every write but one to the interrupt status marks the display as needing a refresh.
               invalidate_flag_in = 1'b1;
               if (is_dither) begin
                  dither_words_in[dither_idx] = s1_wdata;
               end else begin
                  case (s1_addr)
                     ADDR_CONTROL: begin
                        out_pixel_mode_in  = s1_wdata[12];
                        dma_watermark_in   = s1_wdata[11];
                        burst_length_in    = s1_wdata[10:9];
                        endian_mode_in     = s1_wdata[8];
                        pixel_size_code_in = s1_wdata[6:5];
                        tft_mode_in        = s1_wdata[3];
                        color_mode_in      = s1_wdata[1];
                        display_enable_in  = s1_wdata[0];
                     end
                     ADDR_TIMING0: begin
                        horizontal_timing_in = s1_wdata[31:10];
                        width_code_in        = s1_wdata[9:4];
                     end
                     ADDR_TIMING1: begin
                        vertical_timing_in = s1_wdata[31:10];
                        height_lines_in    = s1_wdata[9:0];
                     end
                     ADDR_TIMING2:   extra_timing_in = s1_wdata;
                     ADDR_SCAN_BASE: scan_base_in    = s1_wdata;
                     ADDR_IRQ_STATUS: begin
                        // The written status overrides the set-on-write flag.
                        base_update_flag_in = s1_wdata[1];
                        invalidate_flag_in  = s1_wdata[0];
                        irq_line_in = (s1_wdata[1] & interrupt_mask_ff[1])
                                      | (s1_wdata[0] & interrupt_mask_ff[0]);
                     end
                     ADDR_IRQ_MASK:  interrupt_mask_in = s1_wdata[3:0];
                     default: ;
                  endcase
               end
            end
            CMD_INVALIDATE: begin
               invalidate_flag_in = 1'b1;
               irq_line_in = (base_update_flag_ff & interrupt_mask_ff[1])
                             | interrupt_mask_ff[0];
            end
            CMD_FRAME_DONE: begin
               // While the display is enabled, a finished frame consumes a pending invalidate.
               if (display_enable_ff) begin
                  if (invalidate_flag_ff) begin
                     irq_line_in = (base_update_flag_ff & interrupt_mask_ff[1])
                                   | interrupt_mask_ff[0];
                  end
                  invalidate_flag_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_pixel_mode_ff    <= 1'b0;
         dma_watermark_ff     <= 1'b0;
         burst_length_ff      <= BURST_RESET;
         endian_mode_ff       <= 1'b0;
         pixel_size_code_ff   <= 2'd0;
         tft_mode_ff          <= 1'b0;
         color_mode_ff        <= 1'b0;
         display_enable_ff    <= 1'b0;
         horizontal_timing_ff <= 22'd0;
         width_code_ff        <= 6'd0;
         vertical_timing_ff   <= 22'd0;
         height_lines_ff      <= 10'd0;
         extra_timing_ff      <= 32'd0;
         scan_base_ff         <= 32'd0;
         base_update_flag_ff  <= 1'b0;
         invalidate_flag_ff   <= 1'b0;
         interrupt_mask_ff    <= MASK_RESET;
         dither_words_ff      <= DITHER_RESET;
         irq_line_ff          <= 1'b0;
      end else begin
         out_pixel_mode_ff    <= out_pixel_mode_in;
         dma_watermark_ff     <= dma_watermark_in;
         burst_length_ff      <= burst_length_in;
         endian_mode_ff       <= endian_mode_in;
         pixel_size_code_ff   <= pixel_size_code_in;
         tft_mode_ff          <= tft_mode_in;
         color_mode_ff        <= color_mode_in;
         display_enable_ff    <= display_enable_in;
         horizontal_timing_ff <= horizontal_timing_in;
         width_code_ff        <= width_code_in;
         vertical_timing_ff   <= vertical_timing_in;
         height_lines_ff      <= height_lines_in;
         extra_timing_ff      <= extra_timing_in;
         scan_base_ff         <= scan_base_in;
         base_update_flag_ff  <= base_update_flag_in;
         invalidate_flag_ff   <= invalidate_flag_in;
         interrupt_mask_ff    <= interrupt_mask_in;
         dither_words_ff      <= dither_words_in;
         irq_line_ff          <= irq_line_in;
      end
   end

   // Register readback; reads leave all state unchanged.
   logic [31:0] reg_rd;

   always_comb begin
      reg_rd = 32'd0;
      if (is_read) begin
         if (is_dither) begin
            reg_rd = dither_words_ff[dither_idx];
         end else begin
            case (s1_addr)
               ADDR_CONTROL: reg_rd = {19'd0, out_pixel_mode_ff, dma_watermark_ff,
                                       burst_length_ff, endian_mode_ff, 1'b0,
                                       pixel_size_code_ff, 1'b0, tft_mode_ff, 1'b0,
                                       color_mode_ff, display_enable_ff};
               ADDR_TIMING0:      reg_rd = {horizontal_timing_ff, width_code_ff, 4'd0};
               ADDR_TIMING1:      reg_rd = {vertical_timing_ff, height_lines_ff};
               ADDR_TIMING2:      reg_rd = extra_timing_ff;
               ADDR_SCAN_BASE:    reg_rd = scan_base_ff;
               ADDR_CURRENT_BASE: reg_rd = scan_base_ff;
               ADDR_IRQ_STATUS:   reg_rd = {30'd0, base_update_flag_ff, invalidate_flag_ff};
               ADDR_IRQ_MASK:     reg_rd = {28'd0, interrupt_mask_ff};
               default:           reg_rd = 32'd0;
            endcase
         end
      end
   end

   // Line geometry after the transaction.
   logic [10:0] px_in;
   logic [12:0] bytes_in;

   assign px_in    = {1'b0, width_code_in, 4'd0} + 11'd16;
   assign bytes_in = out_pixel_mode_in ? {px_in, 2'd0} : {1'b0, px_in, 1'b0};

   // Second stage: waits for the palette RAM read.
   logic        s2_valid_ff;
   logic [31:0] s2_reg_rd_ff;
   logic        s2_pal_rd_ff;
   logic        s2_endian_ff;
   logic        s2_irq_ff;
   logic [10:0] s2_px_ff;
   logic [12:0] s2_bytes_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_reg_rd_ff <= reg_rd;
      s2_pal_rd_ff <= pal_ctrl.rd_en;
      s2_endian_ff <= endian_mode_ff;
      s2_irq_ff    <= irq_line_in;
      s2_px_ff     <= px_in;
      s2_bytes_ff  <= bytes_in;
   end

   // Result register.
   logic        rsp_strobe_ff;
   rsp_type     rsp_ff;
   logic [31:0] rd_final;

   assign rd_final = s2_pal_rd_ff
                     ? (s2_endian_ff ? swap_halves(pal_rd_data) : pal_rd_data)
                     : s2_reg_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.read_data         <= rd_final;
      rsp_ff.irq_level         <= s2_irq_ff;
      rsp_ff.line_width_pixels <= s2_px_ff;
      rsp_ff.line_bytes        <= s2_bytes_ff;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef ASSERT_OFF
   // Every accepted transaction yields its result strobe after the input, second-stage and result registers.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("result strobe missing after accepted transaction");

   // A bus read never moves the interrupt line.
   assert property (@(posedge clock) disable iff (reset)
      is_read |=> $stable(irq_line_ff))
      else $error("interrupt line changed on a bus read");

   // An invalidate event always leaves the invalidate flag set.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_ff.command == CMD_INVALIDATE)) |=> invalidate_flag_ff)
      else $error("invalidate flag not set by invalidate event");

   // Burst length comes out of reset at its documented value.
   assert property (@(posedge clock)
      reset |=> (burst_length_ff == BURST_RESET))
      else $error("burst length reset value wrong");
`endif

endmodule
